>>> hdl/lkvc_pkg.sv
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants of the lru key/value cache
// Request and response transaction layouts, per-entry control and status
// groups, and the fixed field widths and codes used across the block.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  localparam int KEY_W       = 32;
  localparam int CAP_W       = 5;
  localparam int ENTRIES_DEF = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  localparam logic signed [KEY_W-1:0] NO_VALUE = -32'sd1;
  localparam logic signed [KEY_W-1:0] NO_KEY   = 32'sd0;

  typedef struct packed {
    logic                    mode;
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                    found;
    logic signed [KEY_W-1:0] read_value;
    logic                    evicted;
    logic signed [KEY_W-1:0] evicted_key;
  } rsp_t;

  // update command broadcast to every entry
  typedef struct packed {
    logic en;
    logic inc_all;
    logic wr_key;
    logic wr_val;
  } cell_cmd_t;

  // what each entry reports back
  typedef struct packed {
    logic                    valid;
    logic                    match;
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] value;
  } cell_stat_t;

endpackage

>>> hdl/lru_key_value_cache.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key/value cache, lru replacement
// Register-bank cache with parallel key compare and per-entry recency ranks.
// ----------------------------------------------------------------------------
// usage
//   request channel: drive in_data (mode, key, value) and raise start; the
//   transaction is taken at a clock edge where start is high and busy is low.
//   busy is never raised, so a request can be taken on every cycle
//   response channel: out_valid is high for exactly one cycle with out_data
//   (found, read_value, evicted, evicted_key); the receiver must take it then,
//   there is no back-pressure
//   latency: the response register loads one edge after the request is taken
//   (input register, then one pass of compare/update logic into the response
//   register) and the receiver takes it at the second edge; throughput one
//   transaction per cycle, set by the single-cycle compare over all entries
//   and the rank update done in the same pass
//   configuration: cfg_we with cfg_wdata writes the capacity register; write
//   it only while no transaction is in flight
//   reset: rst_n low clears all valid marks, ranks, occupancy and pending
//   transactions, and sets the capacity to the full entry count
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
  parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  lkvc_pkg::req_t                in_data,
  output logic                          out_valid,
  output lkvc_pkg::rsp_t                out_data,
  input  logic                          cfg_we,
  input  logic [lkvc_pkg::CAP_W-1:0]    cfg_wdata
);

  // rank 0 is most recent; occupancy counts up to the full entry count
  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W  = $clog2(ENTRIES + 1);

  // input register
  logic                 in_vld_r;
  lkvc_pkg::req_t       in_r;

  // response register
  logic                 out_vld_r;
  lkvc_pkg::rsp_t       out_r;

  // capacity and fill state
  logic [lkvc_pkg::CAP_W-1:0] cap_r;
  logic [OCC_W-1:0]           occ_r, occ_nxt;

  // decision results and entry status
  lkvc_pkg::cell_cmd_t          cmd;
  logic [ENTRIES-1:0]           sel;
  logic [RANK_W-1:0]            thresh;
  lkvc_pkg::rsp_t               rsp;
  logic                         occ_inc;
  lkvc_pkg::cell_stat_t         stat [ENTRIES];
  logic [ENTRIES-1:0][RANK_W-1:0] rank;

  // every request goes through in one pass, nothing to hold off
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lkvc_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // one per entry: storage, key compare and rank ageing
  for (genvar g = 0; g < ENTRIES; g++) begin : g_entry
    lkvc_cell #(
      .RANK_W (RANK_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .req    (in_r),
      .cmd    (cmd),
      .sel    (sel[g]),
      .thresh (thresh),
      .stat   (stat[g]),
      .rank   (rank[g])
    );
  end

  // hit / free / victim selection and response build
  lkvc_decide #(
    .ENTRIES (ENTRIES),
    .RANK_W  (RANK_W),
    .OCC_W   (OCC_W)
  ) u_decide (
    .vld     (in_vld_r),
    .req     (in_r),
    .cap     (cap_r),
    .occ     (occ_r),
    .stat    (stat),
    .rank    (rank),
    .cmd     (cmd),
    .sel     (sel),
    .thresh  (thresh),
    .rsp     (rsp),
    .occ_inc (occ_inc)
  );

  // occupancy only grows on a fill; an eviction leaves it unchanged
  assign occ_nxt = occ_inc ? (occ_r + OCC_W'(1)) : occ_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      occ_r     <= occ_nxt;
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      out_r <= rsp;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

>>> hdl/lkvc_cell.sv
// ----------------------------------------------------------------------------
// lkvc_cell: one cache entry
// Holds key, value, valid mark and recency rank, compares its key with the
// request and applies the broadcast update command.
// ----------------------------------------------------------------------------
module lkvc_cell #(
  parameter int RANK_W = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lkvc_pkg::req_t        req,
  input  lkvc_pkg::cell_cmd_t   cmd,
  input  logic                  sel,
  input  logic [RANK_W-1:0]     thresh,
  output lkvc_pkg::cell_stat_t  stat,
  output logic [RANK_W-1:0]     rank
);

  logic                             valid_r, valid_nxt;
  logic [RANK_W-1:0]                rank_r, rank_nxt;
  logic signed [lkvc_pkg::KEY_W-1:0] key_r, key_nxt;
  logic signed [lkvc_pkg::KEY_W-1:0] val_r, val_nxt;

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    if (cmd.en) begin
      if (sel) begin
        valid_nxt = 1'b1;
        rank_nxt  = '0;
        if (cmd.wr_key) begin
          key_nxt = req.key;
        end
        if (cmd.wr_val) begin
          val_nxt = req.value;
        end
      end else if (valid_r && (cmd.inc_all || (rank_r < thresh))) begin
        // ages by one behind the entry moved to the front
        rank_nxt = rank_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rank_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    val_r <= val_nxt;
  end

  assign stat.valid = valid_r;
  assign stat.match = (key_r == req.key);
  assign stat.key   = key_r;
  assign stat.value = val_r;
  assign rank       = rank_r;

endmodule

>>> hdl/lkvc_decide.sv
// ----------------------------------------------------------------------------
// lkvc_decide: request decision logic
// Finds hit, free and victim entries, builds the entry update command and
// the response transaction.
// ----------------------------------------------------------------------------
module lkvc_decide #(
  parameter int ENTRIES = lkvc_pkg::ENTRIES_DEF,
  parameter int RANK_W  = 4,
  parameter int OCC_W   = 5
) (
  input  logic                              vld,
  input  lkvc_pkg::req_t                    req,
  input  logic [lkvc_pkg::CAP_W-1:0]        cap,
  input  logic [OCC_W-1:0]                  occ,
  input  lkvc_pkg::cell_stat_t              stat [ENTRIES],
  input  logic [ENTRIES-1:0][RANK_W-1:0]    rank,
  output lkvc_pkg::cell_cmd_t               cmd,
  output logic [ENTRIES-1:0]                sel,
  output logic [RANK_W-1:0]                 thresh,
  output lkvc_pkg::rsp_t                    rsp,
  output logic                              occ_inc
);

  localparam int CW = (OCC_W > lkvc_pkg::CAP_W) ? OCC_W : lkvc_pkg::CAP_W;

  logic [ENTRIES-1:0] valid_vec, hit_vec, free_vec, vict_vec;
  logic [ENTRIES-1:0] hit_oh, free_oh, vict_oh;
  logic [RANK_W-1:0]  last_rank, hit_rank;
  logic signed [lkvc_pkg::KEY_W-1:0] hit_value, vict_key;
  logic [CW-1:0]      cap_ext, eff_cap;
  logic               room;

  assign last_rank = RANK_W'(occ - OCC_W'(1));

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      valid_vec[i] = stat[i].valid;
      hit_vec[i]   = stat[i].valid && stat[i].match;
      free_vec[i]  = !stat[i].valid;
      vict_vec[i]  = stat[i].valid && (rank[i] == last_rank);
    end
  end

  // isolate lowest set bit
  assign hit_oh  = hit_vec  & (~hit_vec  + ENTRIES'(1));
  assign free_oh = free_vec & (~free_vec + ENTRIES'(1));
  assign vict_oh = vict_vec & (~vict_vec + ENTRIES'(1));

  always_comb begin
    hit_rank  = '0;
    hit_value = '0;
    vict_key  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_rank  = hit_rank  | (rank[i] & {RANK_W{hit_oh[i]}});
      hit_value = hit_value | (stat[i].value & {lkvc_pkg::KEY_W{hit_oh[i]}});
      vict_key  = vict_key  | (stat[i].key & {lkvc_pkg::KEY_W{vict_oh[i]}});
    end
  end

  // capacity of zero acts as one, above the entry count it saturates
  assign cap_ext = CW'(cap);
  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > CW'(ENTRIES)) begin
      eff_cap = CW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end
  assign room = (CW'(occ) < eff_cap);

  always_comb begin
    cmd             = '0;
    sel             = '0;
    thresh          = '0;
    occ_inc         = 1'b0;
    rsp.found       = 1'b0;
    rsp.read_value  = lkvc_pkg::NO_VALUE;
    rsp.evicted     = 1'b0;
    rsp.evicted_key = lkvc_pkg::NO_KEY;
    if (|hit_vec) begin
      rsp.found  = 1'b1;
      cmd.en     = 1'b1;
      sel        = hit_oh;
      thresh     = hit_rank;
      cmd.wr_val = (req.mode == lkvc_pkg::MODE_PUT);
      if (req.mode == lkvc_pkg::MODE_GET) begin
        rsp.read_value = hit_value;
      end
    end else if (req.mode == lkvc_pkg::MODE_PUT) begin
      if (room && (|free_vec)) begin
        cmd.en      = 1'b1;
        cmd.inc_all = 1'b1;
        cmd.wr_key  = 1'b1;
        cmd.wr_val  = 1'b1;
        sel         = free_oh;
        occ_inc     = 1'b1;
      end else if (|valid_vec) begin
        rsp.evicted     = 1'b1;
        rsp.evicted_key = vict_key;
        cmd.en          = 1'b1;
        cmd.wr_key      = 1'b1;
        cmd.wr_val      = 1'b1;
        sel             = vict_oh;
        thresh          = last_rank;
      end
    end
    cmd.en  = cmd.en && vld;
    occ_inc = occ_inc && vld;
  end

endmodule
